// ----- design/mouse_report_event_tracker_assert.svh -----
// Assertion macros shared by the mouse report event tracker RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef MOUSE_REPORT_EVENT_TRACKER_ASSERT_SVH
`define MOUSE_REPORT_EVENT_TRACKER_ASSERT_SVH

// Same-cycle implication.
`define MRT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MRT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mrt_pkg.sv -----
// Shared types and constants for the mouse report event tracker.
// No dependencies; imported by every module of the block.
package mrt_pkg;

  localparam int CFG_W = 13;

  typedef enum logic [1:0] {
    KIND_MOVE   = 2'd0,
    KIND_DOWN   = 2'd1,
    KIND_UP     = 2'd2,
    KIND_SCROLL = 2'd3
  } event_kind_t;

  typedef enum logic [1:0] {
    BTN_NONE   = 2'd0,
    BTN_LEFT   = 2'd1,
    BTN_RIGHT  = 2'd2,
    BTN_MIDDLE = 2'd3
  } button_name_t;

  typedef enum logic [1:0] {
    REG_X_LIMIT      = 2'd0,
    REG_Y_LIMIT      = 2'd1,
    REG_WHEEL_ENABLE = 2'd2
  } cfg_reg_t;

  // Pending event mask bit positions, in emission order
  localparam int EV_MOVE   = 0;
  localparam int EV_LEFT   = 1;
  localparam int EV_RIGHT  = 2;
  localparam int EV_MIDDLE = 3;
  localparam int EV_SCROLL = 4;
  localparam int EV_N      = 5;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd1024;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd768;
  localparam int POS_X_RESET = 512;
  localparam int POS_Y_RESET = 384;

endpackage

// ----- design/mrt_axis_clamp.sv -----
// One cursor axis: adds a signed 8-bit movement and clamps to 0..limit-1 (limit taken as 1..2**COORD_BITS).
// Depends on mrt_pkg for the limit register width.
module mrt_axis_clamp
  import mrt_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0] pos,
  input  logic signed [7:0]     delta,
  input  logic [CFG_W-1:0]      limit,
  output logic [COORD_BITS-1:0] pos_next
);

  localparam int SW = (COORD_BITS + 2 > CFG_W + 1) ? COORD_BITS + 2 : CFG_W + 1;

  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] lim_ext;
  logic signed [SW-1:0] lim_eff;
  logic signed [SW-1:0] top;
  logic signed [SW-1:0] clamped;

  assign top     = SW'(1) <<< COORD_BITS;
  assign lim_ext = $signed({{(SW-CFG_W){1'b0}}, limit});
  assign sum     = $signed({{(SW-COORD_BITS){1'b0}}, pos})
                 + $signed({{(SW-8){delta[7]}}, delta});

  always_comb begin
    // zero acts as one, oversize acts as the full coordinate range
    if (lim_ext == '0) begin
      lim_eff = SW'(1);
    end else if (lim_ext > top) begin
      lim_eff = top;
    end else begin
      lim_eff = lim_ext;
    end
    if (sum < 0) begin
      clamped = '0;
    end else if (sum >= lim_eff) begin
      clamped = lim_eff - SW'(1);
    end else begin
      clamped = sum;
    end
  end

  assign pos_next = clamped[COORD_BITS-1:0];

endmodule

// ----- design/mouse_report_event_tracker.sv -----
// Mouse report event tracker: boot-protocol mouse reports in, cursor events out.
// Usage:
//   s_* channel takes one report per item: tdata = button_bits, move_x,
//   move_y, move_wheel from the lowest byte up.
//   m_* channel gives one event per item; tuser holds event_kind and
//   which_button, tlast marks the final event of a report.
//   cfg_* writes the x limit (0), the y limit (1), wheel_enable (2);
//   cfg_ready is always high. Write only while no events are outstanding.
// Path: a taken report waits in a pending register; each of its events then
//   goes through the output register.
// Throughput: one event per cycle while m_tready stays high; the next report
//   is taken in the same cycle as the last event of the one before is loaded.
//   The figure is set by the single output register draining the pending
//   event mask one bit per cycle.
// Reset: position goes to (512, 384), buttons to released, limits to
//   1024 x 768, wheel disabled; no events pending.
// Stall: when m_tready is low the output holds its event and the pending
//   report stays, so s_tready drops once the pending mask is not drained.
// Depends on mrt_pkg, mrt_axis_clamp and the assertion macro header.
module mouse_report_event_tracker
  import mrt_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  // report input
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,  // button_bits, move_x, move_y, move_wheel
  // event output
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [((2*COORD_BITS+27+7)/8)*8-1:0] m_tdata,
    // cursor_x, cursor_y, delta_x, delta_y, delta_wheel, button_state, zero pad
  output logic [3:0]           m_tuser,  // event_kind, which_button
  output logic                 m_tlast,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

`include "mouse_report_event_tracker_assert.svh"

  localparam int DATA_BITS = 2*COORD_BITS + 27;
  localparam int DATA_W    = ((DATA_BITS + 7) / 8) * 8;

  // configuration
  logic [CFG_W-1:0] x_limit;
  logic [CFG_W-1:0] y_limit;
  logic             wheel_enable;

  // tracked state
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [2:0]            prev_buttons;

  // pending report
  logic [EV_N-1:0]       pend_mask;
  logic [COORD_BITS-1:0] pend_x;
  logic [COORD_BITS-1:0] pend_y;
  logic signed [7:0]     pend_dx;
  logic signed [7:0]     pend_dy;
  logic signed [7:0]     pend_dw;
  logic [2:0]            pend_btn;
  button_name_t          pend_scroll_name;

  // output register
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic signed [7:0]     out_dx;
  logic signed [7:0]     out_dy;
  logic signed [7:0]     out_dw;
  logic [2:0]            out_btn;
  event_kind_t           out_kind;
  button_name_t          out_which;

  // input decode
  logic [2:0]            in_buttons;
  logic signed [7:0]     in_dx;
  logic signed [7:0]     in_dy;
  logic signed [7:0]     in_dw;
  logic [2:0]            in_chg;
  logic [EV_N-1:0]       in_mask;
  button_name_t          in_scroll_name;
  logic [COORD_BITS-1:0] pos_x_next;
  logic [COORD_BITS-1:0] pos_y_next;

  // emission control
  logic                  s_accept;
  logic                  pend_any;
  logic                  load;
  logic [EV_N-1:0]       pick;
  logic [EV_N-1:0]       pend_rest;
  event_kind_t           sel_kind;
  button_name_t          sel_which;

  assign in_buttons = s_tdata[2:0];
  assign in_dx      = s_tdata[15:8];
  assign in_dy      = s_tdata[23:16];
  assign in_dw      = wheel_enable ? s_tdata[31:24] : 8'sd0;
  assign in_chg     = in_buttons ^ prev_buttons;

  always_comb begin
    in_mask            = '0;
    in_mask[EV_MOVE]   = (in_dx != 8'sd0) || (in_dy != 8'sd0);
    in_mask[EV_LEFT]   = in_chg[0];
    in_mask[EV_RIGHT]  = in_chg[1];
    in_mask[EV_MIDDLE] = in_chg[2];
    in_mask[EV_SCROLL] = (in_dw != 8'sd0);
    // scroll names the last button changed in this report
    priority if (in_chg[2]) begin
      in_scroll_name = BTN_MIDDLE;
    end else if (in_chg[1]) begin
      in_scroll_name = BTN_RIGHT;
    end else if (in_chg[0]) begin
      in_scroll_name = BTN_LEFT;
    end else begin
      in_scroll_name = BTN_NONE;
    end
  end

  mrt_axis_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
    .pos      (pos_x),
    .delta    (in_dx),
    .limit    (x_limit),
    .pos_next (pos_x_next)
  );

  mrt_axis_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
    .pos      (pos_y),
    .delta    (in_dy),
    .limit    (y_limit),
    .pos_next (pos_y_next)
  );

  // pick the earliest pending event
  assign pend_any  = |pend_mask;
  assign pick      = pend_mask & (~pend_mask + EV_N'(1));
  assign pend_rest = pend_mask & ~pick;
  assign load      = pend_any && (!m_tvalid || m_tready);
  assign s_tready  = !pend_any || (load && (pend_rest == '0));
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    sel_kind  = KIND_MOVE;
    sel_which = BTN_NONE;
    priority if (pick[EV_MOVE]) begin
      sel_kind  = KIND_MOVE;
      sel_which = BTN_NONE;
    end else if (pick[EV_LEFT]) begin
      sel_kind  = pend_btn[0] ? KIND_DOWN : KIND_UP;
      sel_which = BTN_LEFT;
    end else if (pick[EV_RIGHT]) begin
      sel_kind  = pend_btn[1] ? KIND_DOWN : KIND_UP;
      sel_which = BTN_RIGHT;
    end else if (pick[EV_MIDDLE]) begin
      sel_kind  = pend_btn[2] ? KIND_DOWN : KIND_UP;
      sel_which = BTN_MIDDLE;
    end else begin
      sel_kind  = KIND_SCROLL;
      sel_which = pend_scroll_name;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit      <= WIDTH_RESET;
      y_limit      <= HEIGHT_RESET;
      wheel_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_X_LIMIT:      x_limit      <= cfg_data;
        REG_Y_LIMIT:      y_limit      <= cfg_data;
        REG_WHEEL_ENABLE: wheel_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // tracked state and pending mask
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x        <= COORD_BITS'(POS_X_RESET);
      pos_y        <= COORD_BITS'(POS_Y_RESET);
      prev_buttons <= '0;
      pend_mask    <= '0;
    end else if (s_accept) begin
      pos_x        <= pos_x_next;
      pos_y        <= pos_y_next;
      prev_buttons <= in_buttons;
      pend_mask    <= in_mask;
    end else if (load) begin
      pend_mask    <= pend_rest;
    end
  end

  // pending payload
  always_ff @(posedge clk) begin
    if (s_accept) begin
      pend_x           <= pos_x_next;
      pend_y           <= pos_y_next;
      pend_dx          <= in_dx;
      pend_dy          <= in_dy;
      pend_dw          <= in_dw;
      pend_btn         <= in_buttons;
      pend_scroll_name <= in_scroll_name;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_x     <= pend_x;
      out_y     <= pend_y;
      out_dx    <= pend_dx;
      out_dy    <= pend_dy;
      out_dw    <= pend_dw;
      out_btn   <= pend_btn;
      out_kind  <= sel_kind;
      out_which <= sel_which;
      m_tlast   <= (pend_rest == '0);
    end
  end

  assign m_tdata = {{(DATA_W-DATA_BITS){1'b0}}, out_btn, out_dw, out_dy, out_dx,
                    out_y, out_x};
  assign m_tuser = {out_which, out_kind};

  `MRT_ASSERT_NOW(a_accept_drains, s_accept && pend_any,
    load && (pend_rest == '0), "report taken while pending events remain")
  `MRT_ASSERT_NEXT(a_load_shows, load, m_tvalid,
    "loaded event not presented")
  `MRT_ASSERT_NOW(a_move_names_none, m_tvalid && (out_kind == KIND_MOVE),
    out_which == BTN_NONE, "move event names a button")
  `MRT_ASSERT_NOW(a_button_named, m_tvalid && (out_kind == KIND_DOWN ||
    out_kind == KIND_UP), out_which != BTN_NONE, "button event without a name")
  `MRT_ASSERT_NEXT(a_last_empties, load && (pend_rest == '0) && !s_accept,
    !pend_any, "pending mask not empty after final event")

endmodule

// ----- tb/tb.sv -----
// Testbench for mouse_report_event_tracker: directed and random mouse reports,
// each event checked field by field against an in-bench cursor and button tracker.
// Depends on mrt_pkg and the RTL of the block; reads no files.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mrt_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int EV_DATA_W = ((2*COORD_BITS+27+7)/8)*8;
  localparam int CYCLE_LIMIT = 150000;
  localparam int SETTLE_CYCLES = 8;
  localparam int SHOW_LIMIT = 10;
  // index with no register behind it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // packs straight onto s_tdata: button byte lowest, wheel highest
  typedef struct packed {
    logic signed [7:0] wheel;
    logic signed [7:0] y;
    logic signed [7:0] x;
    logic [7:0]        buttons;
  } report_t;

  typedef struct packed {
    event_kind_t  kind;
    button_name_t name;
    logic [11:0]  cx;
    logic [11:0]  cy;
    logic [7:0]   dx;
    logic [7:0]   dy;
    logic [7:0]   dw;
    logic [2:0]   btn;
    logic         last;
  } cursor_event_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [EV_DATA_W-1:0] m_tdata;
  logic [3:0]           m_tuser;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  mouse_report_event_tracker #(.COORD_BITS(COORD_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tracker copy of the block's state and registers
  int               cur_x = POS_X_RESET;
  int               cur_y = POS_Y_RESET;
  logic [2:0]       held_btn = 3'b000;
  logic [CFG_W-1:0] width_lim = WIDTH_RESET;
  logic [CFG_W-1:0] height_lim = HEIGHT_RESET;
  logic             wheel_on = 1'b0;

  report_t       report_q[$];
  cursor_event_t event_q[$];
  logic [2:0]    gen_btn = 3'b000;
  bit            calm = 1'b0;
  int            send_idle = 0;
  int            recv_idle = 0;
  int            errors = 0;
  int            reports_taken = 0;
  int            events_seen = 0;
  int            settings_used = 1;
  int            kind_count[4] = '{0, 0, 0, 0};
  int            cycle_count = 0;

  function automatic int clamp_coord(int v, logic [CFG_W-1:0] lim);
    int top;
    top = int'(lim);
    if (top < 1) top = 1;
    if (top > (1 << COORD_BITS)) top = 1 << COORD_BITS;
    if (v < 0) return 0;
    if (v >= top) return top - 1;
    return v;
  endfunction

  // update position and buttons, queue the events this report causes
  function automatic void track_report(report_t r);
    logic [2:0]    btn;
    int            dx;
    int            dy;
    int            dw;
    int            i;
    int            k;
    button_name_t  named;
    cursor_event_t ev;
    cursor_event_t evs[$];
    btn = r.buttons[2:0];
    dx = $signed(r.x);
    dy = $signed(r.y);
    dw = wheel_on ? $signed(r.wheel) : 0;
    cur_x = clamp_coord(cur_x + dx, width_lim);
    cur_y = clamp_coord(cur_y + dy, height_lim);
    named = BTN_NONE;
    ev.cx = cur_x[11:0];
    ev.cy = cur_y[11:0];
    ev.dx = r.x;
    ev.dy = r.y;
    ev.dw = dw[7:0];
    ev.btn = btn;
    ev.last = 1'b0;
    if (dx != 0 || dy != 0) begin
      ev.kind = KIND_MOVE;
      ev.name = BTN_NONE;
      evs.push_back(ev);
    end
    for (i = 0; i < 3; i++) begin
      if (btn[i] != held_btn[i]) begin
        named = (i == 0) ? BTN_LEFT : (i == 1) ? BTN_RIGHT : BTN_MIDDLE;
        ev.kind = btn[i] ? KIND_DOWN : KIND_UP;
        ev.name = named;
        evs.push_back(ev);
      end
    end
    if (dw != 0) begin
      ev.kind = KIND_SCROLL;
      ev.name = named;
      evs.push_back(ev);
    end
    held_btn = btn;
    for (k = 0; k < evs.size(); k++) begin
      ev = evs[k];
      ev.last = (k == evs.size() - 1);
      event_q.push_back(ev);
    end
  endfunction

  function automatic string describe(cursor_event_t e);
    return $sformatf("kind %0d btn %0d x %0d y %0d dx %0d dy %0d dw %0d buttons %b last %b",
                     e.kind, e.name, e.cx, e.cy, $signed(e.dx), $signed(e.dy),
                     $signed(e.dw), e.btn, e.last);
  endfunction

  function automatic report_t report_of(int b, int x, int y, int w);
    report_t r;
    r.buttons = 8'(b);
    r.x = 8'(x);
    r.y = 8'(y);
    r.wheel = 8'(w);
    return r;
  endfunction

  function automatic logic signed [7:0] move_byte(bit climb);
    if (climb) return 8'($urandom_range(96, 127));
    if ($urandom_range(0, 3) == 0) return 8'sd0;
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly single-button toggles and moves; a few empty or all-random reports
  function automatic report_t random_report(bit climb);
    report_t r;
    int      pick;
    pick = $urandom_range(0, 15);
    r.buttons = 8'($urandom_range(0, 255));
    if (pick < 2) begin
      r.buttons[2:0] = gen_btn;
      r.x = 8'sd0;
      r.y = 8'sd0;
      r.wheel = wheel_on ? 8'sd0 : 8'($urandom_range(0, 255));
      return r;
    end
    if (pick < 8) r.buttons[2:0] = gen_btn ^ (3'b001 << $urandom_range(0, 2));
    else if (pick < 11) r.buttons[2:0] = gen_btn;
    gen_btn = r.buttons[2:0];
    r.x = move_byte(climb);
    r.y = move_byte(climb);
    r.wheel = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'sd0;
    return r;
  endfunction

  // report sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_idle = 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) void'(report_q.pop_front());
      if (send_idle > 0) begin
        send_idle--;
        s_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        send_idle = $urandom_range(1, 7) - 1;
        s_tvalid <= 1'b0;
      end else if (report_q.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= report_q[0];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      track_report(report_t'(s_tdata));
      reports_taken++;
    end
  end

  // event receiver and checker
  always @(posedge clk) begin
    cursor_event_t got;
    cursor_event_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_idle = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.kind = event_kind_t'(m_tuser[1:0]);
        got.name = button_name_t'(m_tuser[3:2]);
        got.cx = m_tdata[11:0];
        got.cy = m_tdata[23:12];
        got.dx = m_tdata[31:24];
        got.dy = m_tdata[39:32];
        got.dw = m_tdata[47:40];
        got.btn = m_tdata[50:48];
        got.last = m_tlast;
        if (event_q.size() == 0) begin
          errors++;
          if (errors <= SHOW_LIMIT) $display("unexpected event: %s", describe(got));
        end else begin
          want = event_q.pop_front();
          events_seen++;
          kind_count[want.kind]++;
          if (got !== want) begin
            errors++;
            if (errors <= SHOW_LIMIT)
              $display("mismatch on event %0d\n  expected %s\n  actual   %s",
                       events_seen, describe(want), describe(got));
          end
        end
      end
      if (recv_idle > 0) begin
        recv_idle--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        recv_idle = $urandom_range(1, 7) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events outstanding", cycle_count,
               event_q.size());
      $display("tb: errors");
      $finish;
    end
  end

  task automatic send(report_t r);
    report_q.push_back(r);
  endtask

  // hold until every report is taken and every event is out, then let the block settle
  task automatic drain();
    while (report_q.size() != 0 || s_tvalid || event_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_X_LIMIT:      width_lim = val;
      REG_Y_LIMIT:      height_lim = val;
      REG_WHEEL_ENABLE: wheel_on = val[0];
      default: ;
    endcase
  endtask

  task automatic set_screen(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [CFG_W-1:0] wheel);
    write_reg(REG_X_LIMIT, w);
    write_reg(REG_Y_LIMIT, h);
    write_reg(REG_WHEEL_ENABLE, wheel);
    settings_used++;
  endtask

  task automatic random_phase(int count, int climb);
    int n;
    @(negedge clk);
    for (n = 0; n < count; n++) send(random_report(n < climb));
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset limits, wheel off
    send(report_of(8'h00, 0, 0, 0));          // empty report
    send(report_of(8'h00, 0, 0, -128));       // wheel ignored while disabled
    send(report_of(8'hF8, 0, 0, 0));          // only unused button bits
    send(report_of(8'hFF, 127, -128, 127));   // move plus three downs
    send(report_of(8'h00, 0, 0, 0));          // three ups
    send(report_of(8'h01, 0, 1, 0));
    send(report_of(8'h02, -1, 0, 0));
    send(report_of(8'h04, 0, 0, 0));
    send(report_of(8'h00, -128, 0, 0));
    repeat (5) send(report_of(8'h00, -128, -128, 0));  // pin at the origin
    drain();

    write_reg(REG_WHEEL_ENABLE, 13'd1);
    @(negedge clk);
    send(report_of(8'h00, 0, 0, 127));        // scroll alone names no button
    send(report_of(8'h07, 127, 127, -128));   // a move, three downs and a scroll in one report
    send(report_of(8'h05, 0, 0, 1));
    send(report_of(8'h05, 0, 0, 0));
    drain();

    // zero limits act as one
    write_reg(REG_X_LIMIT, 13'd0);
    write_reg(REG_Y_LIMIT, 13'd0);
    @(negedge clk);
    send(report_of(8'h05, 5, -5, 0));
    drain();

    write_reg(REG_X_LIMIT, WIDTH_RESET);
    write_reg(REG_Y_LIMIT, HEIGHT_RESET);
    @(negedge clk);
    repeat (4) send(report_of(8'h05, 127, 127, 0));
    drain();

    // lowered limits leave the position alone until the next report
    write_reg(REG_X_LIMIT, 13'd100);
    write_reg(REG_Y_LIMIT, 13'd100);
    @(negedge clk);
    send(report_of(8'h05, -1, -1, 0));
    send(report_of(8'h05, 0, 0, 0));
    drain();
    gen_btn = 3'b101;
    settings_used += 4;

    set_screen(13'd640, 13'd480, 13'd1);
    random_phase(50, 0);
    set_screen(13'd8191, 13'd5000, 13'd1);   // both above the coordinate range
    random_phase(60, 40);
    set_screen(13'd1, 13'd2, 13'h1FFE);      // wheel bit clear, other bits set
    random_phase(30, 0);
    set_screen(13'd100, 13'd8191, 13'd1);
    write_reg(REG_UNUSED, 13'h0155);
    random_phase(35, 0);
    set_screen(13'd4096, 13'd1, 13'd0);
    random_phase(35, 0);
    calm = 1'b1;
    set_screen(WIDTH_RESET, HEIGHT_RESET, 13'd1);
    random_phase(35, 0);

    $display("summary: %0d reports over %0d register settings, %0d events checked",
             reports_taken, settings_used, events_seen);
    $display("summary: move %0d, down %0d, up %0d, scroll %0d; %0d mismatches",
             kind_count[KIND_MOVE], kind_count[KIND_DOWN], kind_count[KIND_UP],
             kind_count[KIND_SCROLL], errors);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
